// ----- rtl/core/priority_ready_queue_assert.svh -----
// Assertion macros used by the priority ready queue top level.
// Depends on nothing; expects clk and rst in the scope of each use.
`ifndef PRIORITY_READY_QUEUE_ASSERT_SVH
`define PRIORITY_READY_QUEUE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PRQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, checked outside reset.
`define PRQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ----- rtl/core/prq_pkg.sv -----
// Types and constants of the priority ready queue.
// Used by prq_cell and priority_ready_queue; depends on nothing.
package prq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int PID_W       = 16;
  localparam int PRIO_W      = 8;

  typedef enum logic [0:0] {
    OP_ADD   = 1'b0,
    OP_SCHED = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_SWITCHED = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_ADDED    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // Running minimum handed from cell to cell.
  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  idx;
    entry_t            entry;
  } wave_t;

  // Commands broadcast to every cell.
  typedef struct packed {
    logic              add;
    logic              remove;
    logic [IDX_W-1:0]  sel_idx;
    entry_t            new_entry;
  } cell_ctl_t;

endpackage

// ----- rtl/core/prq_cell.sv -----
// One slot of the ready queue: entry, valid bit and one stage of the min wave.
// Depends on prq_pkg.
module prq_cell
  import prq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cell_ctl_t        ctl,
  input  logic [IDX_W-1:0] cell_idx,
  input  logic             prev_valid,
  input  logic             next_valid,
  input  entry_t           next_entry,
  input  wave_t            wave_in,
  output logic             valid,
  output entry_t           entry,
  output wave_t            wave_out
);

  logic   shift;
  logic   write;
  logic   take;
  wave_t  wave_next;

  // Close the gap left by the removed entry; fill the first free slot.
  assign shift = ctl.remove && (cell_idx >= ctl.sel_idx);
  assign write = ctl.add && !valid && prev_valid;

  // Strictly smaller only, so the older entry keeps a tie.
  assign take = valid && (!wave_in.found || (entry.prio < wave_in.entry.prio));

  always_comb begin
    wave_next = wave_in;
    if (take) begin
      wave_next.found = 1'b1;
      wave_next.idx   = cell_idx;
      wave_next.entry = entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= next_valid;
    end else if (write) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      entry <= next_entry;
    end else if (write) begin
      entry <= ctl.new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_out.found <= 1'b0;
    end else begin
      wave_out.found <= wave_next.found;
    end
    wave_out.idx   <= wave_next.idx;
    wave_out.entry <= wave_next.entry;
  end

endmodule

// ----- rtl/core/priority_ready_queue.sv -----
// Top level of the priority ready queue: handshake, sequencer, row of cells.
// Depends on prq_pkg, prq_cell and priority_ready_queue_assert.svh.
//
// Usage: each transaction on the s_axis side is one command. s_axis_tuser
// selects add (0) or schedule (1); s_axis_tdata carries the process id and
// priority of an add. Each command yields exactly one transaction on the
// m_axis side: m_axis_tuser holds the status, m_axis_tdata the removed entry
// (zero unless the status is "switched").
// Sequence: an add goes from acceptance straight to the finish step; a
// schedule first passes the scan step, in which the running minimum walks
// the row of cells, one cell per cycle. The finish step commits the command
// and loads its result into the output register. One command is in flight
// at a time: no new command is taken until the last one is committed, but
// one is taken while an earlier result still waits in the output register.
// Reset empties the queue at once (valid bits clear); slot contents are left.
// When the receiver stalls, the finished command holds in the finish step
// and the queue is only updated once its result can be loaded.
`include "priority_ready_queue_assert.svh"

module priority_ready_queue
  import prq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [15:0] new_pid, [23:16] new_priority
  input  logic [0:0]  s_axis_tuser,   // [0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [15:0] chosen_pid, [23:16] chosen_priority
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] scan_cnt;
  opcode_t          hold_op;
  entry_t           hold_entry;
  logic             out_free;
  logic             finish;
  cell_ctl_t        ctl;
  logic [QUEUE_DEPTH-1:0] valid_vec;
  entry_t           entry_arr [QUEUE_DEPTH];
  wave_t            wave_arr  [QUEUE_DEPTH];
  wave_t            wave_last;
  status_t          res_status;
  entry_t           res_entry;

  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign wave_last = wave_arr[QUEUE_DEPTH-1];
  assign s_axis_tready = (state == S_IDLE);

  // Sequencer: accept, walk the wave for a schedule, then commit and report.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    finish     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = (opcode_t'(s_axis_tuser[0]) == OP_SCHED) ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        if (scan_cnt == IDX_W'(QUEUE_DEPTH - 1)) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Count the cycles the wave needs to cross the whole row.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
    end else if (state == S_SCAN) begin
      scan_cnt <= scan_cnt + 1'b1;
    end else begin
      scan_cnt <= '0;
    end
  end

  // Hold the accepted command until it is committed.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      hold_op         <= opcode_t'(s_axis_tuser[0]);
      hold_entry.pid  <= s_axis_tdata[15:0];
      hold_entry.prio <= s_axis_tdata[23:16];
    end
  end

  assign ctl.add       = finish && (hold_op == OP_ADD);
  assign ctl.remove    = finish && (hold_op == OP_SCHED) && valid_vec[0];
  assign ctl.sel_idx   = wave_last.idx;
  assign ctl.new_entry = hold_entry;

  // Row of cells, oldest entry in cell 0.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   prev_valid;
    logic   next_valid;
    entry_t next_entry;
    wave_t  wave_in;

    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
      assign wave_in    = '0;
    end else begin : g_inner
      assign prev_valid = valid_vec[i-1];
      assign wave_in    = wave_arr[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_valid = 1'b0;
      assign next_entry = '0;
    end else begin : g_body
      assign next_valid = valid_vec[i+1];
      assign next_entry = entry_arr[i+1];
    end

    prq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .cell_idx   (IDX_W'(i)),
      .prev_valid (prev_valid),
      .next_valid (next_valid),
      .next_entry (next_entry),
      .wave_in    (wave_in),
      .valid      (valid_vec[i]),
      .entry      (entry_arr[i]),
      .wave_out   (wave_arr[i])
    );
  end

  // Result of the command being committed.
  always_comb begin
    res_entry = '0;
    if (hold_op == OP_ADD) begin
      res_status = valid_vec[QUEUE_DEPTH-1] ? ST_FULL : ST_ADDED;
    end else if (valid_vec[0]) begin
      res_status = ST_SWITCHED;
      res_entry  = wave_last.entry;
    end else begin
      res_status = ST_EMPTY;
    end
  end

  // Output register: load on commit, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (finish) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_axis_tuser <= res_status;
      m_axis_tdata <= {res_entry.prio, res_entry.pid};
    end
  end

  // Valid slots always form a prefix of the row.
  `PRQ_ASSERT_IMP(a_valid_prefix, 1'b1,
    ((valid_vec & (valid_vec + 1'b1)) == '0))
  // A non-empty schedule always finds an entry.
  `PRQ_ASSERT_IMP(a_wave_found,
    (state == S_FINISH) && (hold_op == OP_SCHED) && valid_vec[0], wave_last.found)
  // Only a switch carries an entry.
  `PRQ_ASSERT_IMP(a_zero_payload,
    m_axis_tvalid && (m_axis_tuser != ST_SWITCHED), (m_axis_tdata == '0))
  // A committed removal shrinks the queue by exactly one entry.
  `PRQ_ASSERT_NXT(a_remove_shrinks,
    ctl.remove, ($countones(valid_vec) == $countones($past(valid_vec)) - 1))

endmodule
